/* rtl/core/cld_pkg.sv */
`default_nettype none
package cld_pkg;

   localparam int PREFIX_LEN = 16;

   // Header line prefix, one byte per position.
   localparam logic [7:0] PREFIX [PREFIX_LEN] = '{
      8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
      8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
   };

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // One received byte with its character class.
   typedef struct packed {
      logic [7:0] data;
      logic       is_cr;
      logic       is_lf;
      logic       is_digit;
      logic       is_ws;
      logic       is_sign;
      logic       is_minus;
   } class_type;

   // A CR that turned out not to end the line.
   localparam class_type CR_CLASS = '{
      data: CHAR_CR, is_cr: 1'b1, is_lf: 1'b0, is_digit: 1'b0,
      is_ws: 1'b1, is_sign: 1'b0, is_minus: 1'b0
   };

   typedef struct packed {
      kind_type   kind;
      logic [7:0] body_byte;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

/* rtl/core/cld_fifo.sv */
`default_nettype none
module cld_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/cld_front.sv */
`default_nettype none
module cld_front (
   input  wire logic [7:0]         rx_byte,
   output cld_pkg::class_type      byte_class
);
   import cld_pkg::*;

   always_comb begin
      byte_class.data     = rx_byte;
      byte_class.is_cr    = (rx_byte == CHAR_CR);
      byte_class.is_lf    = (rx_byte == CHAR_LF);
      byte_class.is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
      // space, or tab through CR
      byte_class.is_ws    = (rx_byte == 8'h20) || ((rx_byte >= 8'h09) && (rx_byte <= 8'h0D));
      byte_class.is_sign  = (rx_byte == 8'h2B) || (rx_byte == 8'h2D);
      byte_class.is_minus = (rx_byte == 8'h2D);
   end

endmodule
`default_nettype wire

/* rtl/core/cld_back.sv */
`default_nettype none
module cld_back #(
   parameter int LEN_BITS = 24
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire cld_pkg::class_type  in_class,
   output logic                     in_take,
   input  wire logic                out_full,
   output logic                     out_valid,
   output cld_pkg::result_type      out_result
);
   import cld_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_BODY,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      NUM_WS,
      NUM_SIGN,
      NUM_DIGITS,
      NUM_DONE
   } num_type;

   typedef struct packed {
      logic [4:0]      pos;
      logic            bad;
      num_type         nphase;
      logic            neg;
      logic [LEN_BITS:0] acc;
   } line_type;

   localparam line_type LINE_RESET = '{
      pos: '0, bad: 1'b0, nphase: NUM_WS, neg: 1'b0, acc: '0
   };
   localparam logic [LEN_BITS+4:0] GROWN_MAX = (LEN_BITS+5)'({LEN_BITS{1'b1}});
   localparam logic [LEN_BITS:0]   ACC_LIMIT = {1'b1, {LEN_BITS{1'b0}}};

   // Advance the header line parse by one byte.
   function automatic line_type line_step(line_type s, class_type c);
      line_type            n;
      logic [LEN_BITS+4:0] grown;
      n     = s;
      grown = '0;
      if (s.pos < 5'd16) begin
         if (c.data != PREFIX[s.pos[3:0]]) begin
            n.bad = 1'b1;
         end
      end else begin
         unique case (s.nphase)
            NUM_WS: begin
               if (c.is_ws) begin
                  n.nphase = NUM_WS;
               end else if (c.is_sign) begin
                  n.neg    = c.is_minus;
                  n.nphase = NUM_SIGN;
               end else if (!c.is_digit) begin
                  n.bad    = 1'b1;
                  n.nphase = NUM_DONE;
               end
            end
            NUM_SIGN: begin
               if (!c.is_digit) begin
                  n.bad    = 1'b1;
                  n.nphase = NUM_DONE;
               end
            end
            NUM_DIGITS: begin
               if (!c.is_digit) begin
                  n.nphase = NUM_DONE;
               end
            end
            NUM_DONE: begin
               n.nphase = NUM_DONE;
            end
         endcase
         if (c.is_digit && (s.nphase != NUM_DONE)) begin
            n.nphase = NUM_DIGITS;
            grown = ((LEN_BITS+5)'(s.acc) << 3) + ((LEN_BITS+5)'(s.acc) << 1)
                  + (LEN_BITS+5)'(c.data[3:0]);
            n.acc = (grown > GROWN_MAX) ? ACC_LIMIT : grown[LEN_BITS:0];
         end
      end
      if (s.pos < 5'd17) begin
         n.pos = s.pos + 5'd1;
      end
      return n;
   endfunction

   phase_type           phase_ff, phase_in;
   logic                cr_seen_ff, cr_seen_in;
   line_type            line_ff, line_in;
   logic                skip_ff, skip_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic [LEN_BITS-1:0] left_dec;
   logic                line_fails;

   assign in_take  = in_valid && !out_full;
   assign left_dec = left_ff - 1'b1;
   assign line_fails = (line_ff.pos < 5'd16) || line_ff.bad
                    || (line_ff.nphase == NUM_WS) || (line_ff.nphase == NUM_SIGN)
                    || (line_ff.neg && (line_ff.acc != '0)) || line_ff.acc[LEN_BITS];

   always_comb begin
      phase_in   = phase_ff;
      cr_seen_in = cr_seen_ff;
      line_in    = line_ff;
      skip_in    = skip_ff;
      left_in    = left_ff;
      out_valid  = 1'b0;
      out_result = '{kind: KIND_BODY, body_byte: 8'h00, last: 1'b0};
      if (in_take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (!cr_seen_ff) begin
                  if (in_class.is_cr) begin
                     cr_seen_in = 1'b1;
                  end else begin
                     line_in = line_step(line_ff, in_class);
                  end
               end else begin
                  cr_seen_in = 1'b0;
                  if (!in_class.is_lf) begin
                     // lone CR: both bytes belong to the line
                     line_in = line_step(line_step(line_ff, CR_CLASS), in_class);
                  end else if (line_fails) begin
                     phase_in        = PH_HALT;
                     out_valid       = 1'b1;
                     out_result.kind = KIND_ERROR;
                  end else begin
                     left_in  = line_ff.acc[LEN_BITS-1:0];
                     skip_in  = 1'b0;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (!skip_ff) begin
                  skip_in = 1'b1;
               end else begin
                  skip_in    = 1'b0;
                  line_in    = LINE_RESET;
                  cr_seen_in = 1'b0;
                  if (left_ff == '0) begin
                     phase_in        = PH_HEADER;
                     out_valid       = 1'b1;
                     out_result.kind = KIND_EMPTY;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               left_in              = left_dec;
               out_valid            = 1'b1;
               out_result.body_byte = in_class.data;
               if (left_dec == '0) begin
                  out_result.last = 1'b1;
                  phase_in        = PH_HEADER;
                  line_in         = LINE_RESET;
                  cr_seen_in      = 1'b0;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         cr_seen_ff <= 1'b0;
         line_ff    <= LINE_RESET;
         skip_ff    <= 1'b0;
         left_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         cr_seen_ff <= cr_seen_in;
         line_ff    <= line_in;
         skip_ff    <= skip_in;
         left_ff    <= left_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/content_length_deframer.sv */
`default_nettype none
// Content-length deframer: takes one received byte per request and strips
// "Content-Length: N" header lines (CR LF terminated), skips the two bytes
// after a good header line and then passes N body bytes out as results, the
// last one flagged by rsp_last. A zero length yields one empty-message result
// (kind 1) instead; a malformed, negative or oversized length yields one
// framing-error result (kind 2), after which input is still taken but dropped
// until reset. Requests sustain one byte per cycle as long as results are
// popped at the same rate. A byte is classified on entry and lands in a
// two-entry queue; the parser takes one byte per cycle from that queue while
// the result queue is not full and writes any result into a two-entry result
// queue. A result thus passes through the request queue and then the result
// queue before it shows on the rsp_ ports and can be popped. req_full rises
// only when the result queue backs up into the parser and the request queue
// fills. The header length accepted is up to 2^LEN_BITS - 1.
module content_length_deframer #(
   parameter int LEN_BITS = 24
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_body_byte,
   output logic            rsp_last
);
   import cld_pkg::*;

   class_type  req_class;
   class_type  queued_class;
   logic       queue_empty;
   logic       parser_take;
   logic       rsp_queue_full;
   logic       result_valid;
   result_type result;
   result_type rsp_head;

   // Classify the incoming byte.
   cld_front u_front (
      .rx_byte    (req_rx_byte),
      .byte_class (req_class)
   );

   // Hold classified bytes until the parser can take them.
   cld_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (2)
   ) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_class),
      .full  (req_full),
      .pop   (parser_take),
      .rdata (queued_class),
      .empty (queue_empty)
   );

   // Parse headers and stream bodies; advance only when a result has room.
   cld_back #(
      .LEN_BITS (LEN_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (!queue_empty),
      .in_class   (queued_class),
      .in_take    (parser_take),
      .out_full   (rsp_queue_full),
      .out_valid  (result_valid),
      .out_result (result)
   );

   // Hold results until the consumer pops them.
   cld_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (result_valid),
      .wdata (result),
      .full  (rsp_queue_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_kind      = rsp_head.kind;
   assign rsp_body_byte = rsp_head.body_byte;
   assign rsp_last      = rsp_head.last;

endmodule
`default_nettype wire
